// ===== rtl/yrs_pkg.sv =====
// Shared types and constants for the YUV to RGB nearest-neighbour scaler.
// Used by yrs_csc, yrs_scan and the top level; depends on nothing else.
package yrs_pkg;

    // Widths fixed by the register and pixel formats.
    localparam int CFG_W = 13;
    localparam int IDX_W = 3;
    localparam int PIX_W = 8;

    // Default largest frame dimension.
    localparam int DEFAULT_MAX_DIM = 4096;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_PASSTHRU   = 3'd4;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 13'd480;
    localparam logic [CFG_W-1:0] RST_DST_WIDTH  = 13'd224;
    localparam logic [CFG_W-1:0] RST_DST_HEIGHT = 13'd224;

    // Colour conversion coefficients, scaled by 256.
    localparam int COEF_RV     = 359;
    localparam int COEF_GU     = 88;
    localparam int COEF_GV     = 183;
    localparam int COEF_BU     = 454;
    localparam int CHROMA_BIAS = 128;
    localparam int PIX_MAX     = 255;

    // Selection decision and end marks for one source pixel.
    typedef struct packed {
        logic sel;
        logic row_end;
        logic frame_end;
    } scan_mark_t;

endpackage

// ===== rtl/yrs_div.sv =====
// Restoring divider, one quotient bit per cycle, for the scaler step sizes.
// Depends on nothing outside this file.
module yrs_div #(
    parameter int W = 13
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     div_reg, div_next;
    logic [W:0]       trial;
    logic             fits;

    // One trial subtraction per cycle.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[W-1]};
        fits      = trial >= {1'b0, div_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[W-2:0], fits};
            rem_next = fits ? W'(trial - {1'b0, div_reg}) : trial[W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state is reset; the datapath needs none.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/yrs_csc.sv =====
// BT.601-style colour space conversion with floor rounding and clipping.
// Depends on yrs_pkg for pixel width and coefficients.
module yrs_csc (
    input  logic [yrs_pkg::PIX_W-1:0] luma,
    input  logic [yrs_pkg::PIX_W-1:0] chroma_u,
    input  logic [yrs_pkg::PIX_W-1:0] chroma_v,
    input  logic                      passthru,
    output logic [yrs_pkg::PIX_W-1:0] red,
    output logic [yrs_pkg::PIX_W-1:0] green,
    output logic [yrs_pkg::PIX_W-1:0] blue
);

    logic signed [9:0]  du;
    logic signed [9:0]  dv;
    logic signed [17:0] r_prod;
    logic signed [17:0] g_prod;
    logic signed [17:0] b_prod;
    logic signed [10:0] y_s;
    logic signed [10:0] r_sum;
    logic signed [10:0] g_sum;
    logic signed [10:0] b_sum;

    // Clip a signed sum to 0..255.
    function automatic logic [yrs_pkg::PIX_W-1:0] clip8(input logic signed [10:0] v);
        logic [yrs_pkg::PIX_W-1:0] res;
        if (v < 11'sd0)
        begin
            res = '0;
        end
        else if (v > 11'(yrs_pkg::PIX_MAX))
        begin
            res = yrs_pkg::PIX_W'(yrs_pkg::PIX_MAX);
        end
        else
        begin
            res = v[yrs_pkg::PIX_W-1:0];
        end
        return res;
    endfunction

    // Centre chroma and apply the coefficients; an arithmetic shift floors.
    always_comb
    begin
        du     = signed'({2'b00, chroma_u}) - 10'(yrs_pkg::CHROMA_BIAS);
        dv     = signed'({2'b00, chroma_v}) - 10'(yrs_pkg::CHROMA_BIAS);
        r_prod = 18'(dv) * 18'(yrs_pkg::COEF_RV);
        g_prod = 18'(du) * 18'(yrs_pkg::COEF_GU) + 18'(dv) * 18'(yrs_pkg::COEF_GV);
        b_prod = 18'(du) * 18'(yrs_pkg::COEF_BU);
        y_s    = signed'({3'b000, luma});
        r_sum  = y_s + 11'(r_prod >>> 8);
        g_sum  = y_s - 11'(g_prod >>> 8);
        b_sum  = y_s + 11'(b_prod >>> 8);
    end

    // Pass-through forwards the fields untouched.
    assign red   = passthru ? luma     : clip8(r_sum);
    assign green = passthru ? chroma_u : clip8(g_sum);
    assign blue  = passthru ? chroma_v : clip8(b_sum);

endmodule

// ===== rtl/yrs_scan.sv =====
// Raster position counters and nearest-neighbour selection of source pixels.
// Depends on yrs_pkg for the mark struct; step sizes come from yrs_div.
module yrs_scan #(
    parameter int MAX_DIM = yrs_pkg::DEFAULT_MAX_DIM
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       restart,
    input  logic                       step,
    input  logic [$clog2(MAX_DIM+1)-1:0] sw,
    input  logic [$clog2(MAX_DIM+1)-1:0] sh,
    input  logic [$clog2(MAX_DIM+1)-1:0] dw,
    input  logic [$clog2(MAX_DIM+1)-1:0] dh,
    input  logic [$clog2(MAX_DIM+1)-1:0] col_q,
    input  logic [$clog2(MAX_DIM+1)-1:0] col_r,
    input  logic [$clog2(MAX_DIM+1)-1:0] row_q,
    input  logic [$clog2(MAX_DIM+1)-1:0] row_r,
    output yrs_pkg::scan_mark_t        mark
);

    localparam int SZ_W  = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);

    logic [CNT_W-1:0] src_col_reg, src_col_next;
    logic [CNT_W-1:0] src_row_reg, src_row_next;
    logic [SZ_W-1:0]  out_col_reg, out_col_next;
    logic [SZ_W-1:0]  out_row_reg, out_row_next;
    logic [SZ_W-1:0]  col_tgt_reg, col_tgt_next;
    logic [SZ_W-1:0]  col_rem_reg, col_rem_next;
    logic [SZ_W-1:0]  row_tgt_reg, row_tgt_next;
    logic [SZ_W-1:0]  row_rem_reg, row_rem_next;

    logic            row_sel;
    logic            pix_sel;
    logic [SZ_W-1:0] out_col_inc;
    logic [SZ_W-1:0] out_row_inc;
    logic [SZ_W-1:0] src_col_inc;
    logic [SZ_W-1:0] src_row_inc;
    logic [SZ_W:0]   col_rem_sum;
    logic [SZ_W:0]   row_rem_sum;
    logic            col_wrap;
    logic            row_wrap;
    logic            line_done;
    logic            frame_done;

    // Selection test and end marks from the current position.
    always_comb
    begin
        out_col_inc = out_col_reg + SZ_W'(1);
        out_row_inc = out_row_reg + SZ_W'(1);
        src_col_inc = SZ_W'(src_col_reg) + SZ_W'(1);
        src_row_inc = SZ_W'(src_row_reg) + SZ_W'(1);
        row_sel = (SZ_W'(src_row_reg) == row_tgt_reg) && (out_row_reg < dh);
        pix_sel = row_sel && (SZ_W'(src_col_reg) == col_tgt_reg) && (out_col_reg < dw);
        mark.sel       = pix_sel;
        mark.row_end   = out_col_inc == dw;
        mark.frame_end = (out_col_inc == dw) && (out_row_inc == dh);
        line_done  = src_col_inc == sw;
        frame_done = line_done && (src_row_inc == sh);
    end

    // Quotient-remainder accumulators for the next column and row targets.
    always_comb
    begin
        col_rem_sum = {1'b0, col_rem_reg} + {1'b0, col_r};
        col_wrap    = col_rem_sum >= {1'b0, dw};
        row_rem_sum = {1'b0, row_rem_reg} + {1'b0, row_r};
        row_wrap    = row_rem_sum >= {1'b0, dh};
    end

    // Next position after one source pixel.
    always_comb
    begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        col_tgt_next = col_tgt_reg;
        col_rem_next = col_rem_reg;
        row_tgt_next = row_tgt_reg;
        row_rem_next = row_rem_reg;
        if (step)
        begin
            if (pix_sel)
            begin
                out_col_next = out_col_inc;
                col_tgt_next = SZ_W'({1'b0, col_tgt_reg} + {1'b0, col_q}
                                     + (SZ_W+1)'(col_wrap));
                col_rem_next = col_wrap ? SZ_W'(col_rem_sum - {1'b0, dw})
                                        : col_rem_sum[SZ_W-1:0];
            end
            src_col_next = src_col_inc[CNT_W-1:0];
            if (line_done)
            begin
                src_col_next = '0;
                out_col_next = '0;
                col_tgt_next = '0;
                col_rem_next = '0;
                if (row_sel)
                begin
                    out_row_next = out_row_inc;
                    row_tgt_next = SZ_W'({1'b0, row_tgt_reg} + {1'b0, row_q}
                                         + (SZ_W+1)'(row_wrap));
                    row_rem_next = row_wrap ? SZ_W'(row_rem_sum - {1'b0, dh})
                                            : row_rem_sum[SZ_W-1:0];
                end
                src_row_next = src_row_inc[CNT_W-1:0];
                if (frame_done)
                begin
                    src_row_next = '0;
                    out_row_next = '0;
                    row_tgt_next = '0;
                    row_rem_next = '0;
                end
            end
        end
    end

    // Position registers; a configuration write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            col_tgt_reg <= '0;
            col_rem_reg <= '0;
            row_tgt_reg <= '0;
            row_rem_reg <= '0;
        end
        else if (restart)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            col_tgt_reg <= '0;
            col_rem_reg <= '0;
            row_tgt_reg <= '0;
            row_rem_reg <= '0;
        end
        else
        begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            col_tgt_reg <= col_tgt_next;
            col_rem_reg <= col_rem_next;
            row_tgt_reg <= row_tgt_next;
            row_rem_reg <= row_rem_next;
        end
    end

    // The output column never runs past the row, and the source column stays inside it.
    a_out_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_col_reg <= dw)
        else $error("output column beyond destination width");

    a_src_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SZ_W'(src_col_reg) < sw)
        else $error("source column beyond source width");

    // A selected pixel that closes a frame also closes the source row's output.
    a_frame_mark: assert property (@(posedge clk) disable iff (!rst_n)
        step && pix_sel && mark.frame_end |-> mark.row_end && (out_row_inc == dh))
        else $error("frame end without row end");

endmodule

// ===== rtl/yuv_to_rgb_nearest_scaler.sv =====
// Top level of the YUV to RGB converter with nearest-neighbour downscaler.
// Depends on yrs_pkg, yrs_div, yrs_scan and yrs_csc.
//
// Usage
//   Source pixels enter on the in_valid/in_ready channel in raster order,
//   one word per pixel carrying luma and its shared chroma_u and chroma_v.
//   Selected pixels leave on the out_valid/out_ready channel as red, green
//   and blue with row_end and frame_end marks; unselected pixels are taken
//   and dropped.
//   When a selected pixel is accepted, the input register holds the pixel,
//   then the conversion loads the result register and out_valid rises.
//   One pixel is taken every cycle while the dividers are idle and the receiver keeps up.
//   When the receiver stalls, the result register holds its word and the
//   input register still takes one more selected pixel before in_ready
//   drops; dropped pixels keep flowing while that register is free.
//   After reset, and after every register write, two restoring dividers
//   work out the column and row step sizes, one bit a cycle, and in_ready
//   is low while they run. A register write also restarts the frame
//   position. The user must write registers on the cfg port only while
//   the block is idle; the block itself does not enforce it.
module yuv_to_rgb_nearest_scaler #(
    parameter int MAX_DIM = yrs_pkg::DEFAULT_MAX_DIM
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [yrs_pkg::IDX_W-1:0]   cfg_index,
    input  logic [yrs_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [yrs_pkg::PIX_W-1:0]   luma,
    input  logic [yrs_pkg::PIX_W-1:0]   chroma_u,
    input  logic [yrs_pkg::PIX_W-1:0]   chroma_v,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [yrs_pkg::PIX_W-1:0]   red,
    output logic [yrs_pkg::PIX_W-1:0]   green,
    output logic [yrs_pkg::PIX_W-1:0]   blue,
    output logic                        row_end,
    output logic                        frame_end
);

    localparam int SZ_W  = $clog2(MAX_DIM + 1);
    localparam int EXT_W = (SZ_W > yrs_pkg::CFG_W) ? SZ_W : yrs_pkg::CFG_W;

    // Configuration registers.
    logic [yrs_pkg::CFG_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic                      passthru_reg;
    logic                      cfg_hit;
    logic                      pend_reg;

    // Effective sizes and step sizes.
    logic [EXT_W-1:0] src_w_ext, src_h_ext, dst_w_ext, dst_h_ext;
    logic [EXT_W-1:0] sw_ext, sh_ext, dw_ext, dh_ext;
    logic [SZ_W-1:0]  sw, sh, dw, dh;
    logic [SZ_W-1:0]  col_q, col_r, row_q, row_r;
    logic             col_busy, row_busy, busy;

    // Pipeline.
    yrs_pkg::scan_mark_t        mark;
    logic                       accept;
    logic                       s1_adv;
    logic                       s1_valid_reg, s1_valid_next;
    logic [yrs_pkg::PIX_W-1:0]  s1_y_reg, s1_u_reg, s1_v_reg;
    logic                       s1_rend_reg, s1_fend_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [yrs_pkg::PIX_W-1:0]  red_reg, green_reg, blue_reg;
    logic                       rend_reg, fend_reg;
    logic [yrs_pkg::PIX_W-1:0]  csc_r, csc_g, csc_b;

    // A write to a known register restarts the frame and the step sizes.
    assign cfg_hit = cfg_write && (cfg_index <= yrs_pkg::REG_PASSTHRU);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg    <= yrs_pkg::RST_SRC_WIDTH;
            src_h_reg    <= yrs_pkg::RST_SRC_HEIGHT;
            dst_w_reg    <= yrs_pkg::RST_DST_WIDTH;
            dst_h_reg    <= yrs_pkg::RST_DST_HEIGHT;
            passthru_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                yrs_pkg::REG_SRC_WIDTH:  src_w_reg    <= cfg_data;
                yrs_pkg::REG_SRC_HEIGHT: src_h_reg    <= cfg_data;
                yrs_pkg::REG_DST_WIDTH:  dst_w_reg    <= cfg_data;
                yrs_pkg::REG_DST_HEIGHT: dst_h_reg    <= cfg_data;
                yrs_pkg::REG_PASSTHRU:   passthru_reg <= cfg_data[0];
                default:                 passthru_reg <= passthru_reg;
            endcase
        end
    end

    // Divider start is pending from reset and after each write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b1;
        end
        else
        begin
            pend_reg <= cfg_hit;
        end
    end

    // Zero reads as one, source sizes saturate, destinations clamp to source.
    always_comb
    begin
        src_w_ext = EXT_W'(src_w_reg);
        src_h_ext = EXT_W'(src_h_reg);
        dst_w_ext = EXT_W'(dst_w_reg);
        dst_h_ext = EXT_W'(dst_h_reg);
        if (src_w_ext == '0)
            sw_ext = EXT_W'(1);
        else if (src_w_ext > EXT_W'(MAX_DIM))
            sw_ext = EXT_W'(MAX_DIM);
        else
            sw_ext = src_w_ext;
        if (src_h_ext == '0)
            sh_ext = EXT_W'(1);
        else if (src_h_ext > EXT_W'(MAX_DIM))
            sh_ext = EXT_W'(MAX_DIM);
        else
            sh_ext = src_h_ext;
        if (dst_w_ext == '0)
            dw_ext = EXT_W'(1);
        else if (dst_w_ext > sw_ext)
            dw_ext = sw_ext;
        else
            dw_ext = dst_w_ext;
        if (dst_h_ext == '0)
            dh_ext = EXT_W'(1);
        else if (dst_h_ext > sh_ext)
            dh_ext = sh_ext;
        else
            dh_ext = dst_h_ext;
    end

    assign sw = sw_ext[SZ_W-1:0];
    assign sh = sh_ext[SZ_W-1:0];
    assign dw = dw_ext[SZ_W-1:0];
    assign dh = dh_ext[SZ_W-1:0];

    // Column and row step sizes: source over destination, with remainder.
    yrs_div #(
        .W (SZ_W)
    ) u_col_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pend_reg),
        .dividend  (sw),
        .divisor   (dw),
        .busy      (col_busy),
        .quotient  (col_q),
        .remainder (col_r)
    );

    yrs_div #(
        .W (SZ_W)
    ) u_row_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pend_reg),
        .dividend  (sh),
        .divisor   (dh),
        .busy      (row_busy),
        .quotient  (row_q),
        .remainder (row_r)
    );

    assign busy = pend_reg || col_busy || row_busy;

    // Handshake: the input register moves on when the result register is free.
    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !busy && (!s1_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;

    yrs_scan #(
        .MAX_DIM (MAX_DIM)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_hit),
        .step    (accept),
        .sw      (sw),
        .sh      (sh),
        .dw      (dw),
        .dh      (dh),
        .col_q   (col_q),
        .col_r   (col_r),
        .row_q   (row_q),
        .row_r   (row_r),
        .mark    (mark)
    );

    // Valid flags of the two stages.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = mark.sel;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register holds the selected pixel and its marks.
    always_ff @(posedge clk)
    begin
        if (accept && mark.sel)
        begin
            s1_y_reg    <= luma;
            s1_u_reg    <= chroma_u;
            s1_v_reg    <= chroma_v;
            s1_rend_reg <= mark.row_end;
            s1_fend_reg <= mark.frame_end;
        end
    end

    yrs_csc u_csc (
        .luma     (s1_y_reg),
        .chroma_u (s1_u_reg),
        .chroma_v (s1_v_reg),
        .passthru (passthru_reg),
        .red      (csc_r),
        .green    (csc_g),
        .blue     (csc_b)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            red_reg   <= csc_r;
            green_reg <= csc_g;
            blue_reg  <= csc_b;
            rend_reg  <= s1_rend_reg;
            fend_reg  <= s1_fend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign row_end   = rend_reg;
    assign frame_end = fend_reg;

    // No pixel is taken while the step sizes are being worked out.
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("pixel accepted while dividers busy");

    // A register write holds off input in the next cycle.
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> !in_ready)
        else $error("input taken right after a register write");

    // Every frame end mark is also a row end mark.
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!frame_end || row_end))
        else $error("frame end without row end at output");

endmodule
